// ===== hdl/double_ended_queue_defines.svh =====
// Assertion macros shared by the double-ended queue RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is held.
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds while reset is held.
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/dq_pkg.sv =====
`default_nettype none
package dq_pkg;

    // Size of the queue and of one stored word.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the ports.
    localparam int MODE_W   = 3;
    localparam int PORT_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Command codes on the mode field.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

    // Status codes on the result.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_count;

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } t_op;

    // What the row reports back to the controller.
    typedef struct packed {
        logic  full;
        logic  empty;
        t_word front;
        t_word back;
    } t_row_status;

endpackage
`default_nettype wire

// ===== hdl/dq_cell.sv =====
`default_nettype none
module dq_cell import dq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_op   i_op,
    input  wire t_word i_word,
    input  wire logic  i_left_valid,
    input  wire t_word i_left_data,
    input  wire logic  i_right_valid,
    input  wire t_word i_right_data,
    output logic       o_valid,
    output t_word      o_data,
    output logic       o_last
);

    logic  r_valid;
    logic  n_valid;
    t_word r_data;
    t_word n_data;

    // Shift toward the back on a front push, toward the front on a front pop.
    // Back push fills the first free cell; back pop clears the last full one.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_op)
            OP_PUSH_FRONT: begin
                n_valid = i_left_valid;
                n_data  = i_left_data;
            end
            OP_PUSH_BACK: begin
                if (!r_valid && i_left_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_word;
                end
            end
            OP_POP_FRONT: begin
                n_valid = i_right_valid;
                n_data  = i_right_data;
            end
            OP_POP_BACK: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // The stored word needs no reset; it is only seen while valid.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_valid & ~i_right_valid;

endmodule
`default_nettype wire

// ===== hdl/dq_row.sv =====
`default_nettype none
module dq_row import dq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_op   i_op,
    input  wire t_word i_word,
    output t_row_status o_status
);

    logic  w_valid [DEPTH];
    t_word w_data  [DEPTH];
    logic  w_last  [DEPTH];
    t_word w_back;

    // Cell zero holds the front word; the valid bits fill from cell zero up.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic  w_lv;
        t_word w_ld;
        logic  w_rv;
        t_word w_rd;

        if (g == 0) begin : g_first
            assign w_lv = 1'b1;
            assign w_ld = i_word;
        end else begin : g_mid_l
            assign w_lv = w_valid[g-1];
            assign w_ld = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_rv = 1'b0;
            assign w_rd = '0;
        end else begin : g_mid_r
            assign w_rv = w_valid[g+1];
            assign w_rd = w_data[g+1];
        end

        dq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (i_op),
            .i_word       (i_word),
            .i_left_valid (w_lv),
            .i_left_data  (w_ld),
            .i_right_valid(w_rv),
            .i_right_data (w_rd),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g]),
            .o_last       (w_last[g])
        );
    end

    // At most one cell marks itself last (none when empty), so an OR picks the back word.
    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | (w_last[i] ? w_data[i] : t_word'(0));
        end
    end

    assign o_status.full  = w_valid[DEPTH-1];
    assign o_status.empty = ~w_valid[0];
    assign o_status.front = w_valid[0] ? w_data[0] : t_word'(0);
    assign o_status.back  = w_back;

endmodule
`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
`default_nettype none
// Bounded double-ended queue of 16 words, built as a row of cells with the
// front word in the first cell. Each input word carries a mode (push front,
// push back, pop front, pop back, peek) and a data word, and yields one
// result with a status (ok, empty on a pop from an empty queue, full on a
// rejected push), the front and back words (zero when empty), the count and
// an empty flag. In the cycle an item is accepted the whole row shifts,
// fills or clears one cell, and in the next the result register loads from
// the first cell and from the OR tree that finds the back cell. The next
// word is accepted in the cycle the result is taken, so a new word never
// enters while the last one is still in flight. No clearing pass follows reset.
`include "double_ended_queue_defines.svh"
module double_ended_queue import dq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic [PORT_W-1:0]   i_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [PORT_W-1:0]        o_front_value,
    output logic [PORT_W-1:0]        o_back_value,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty
);

    logic                r_pend;
    logic [STATUS_W-1:0] r_pend_status;
    logic [STATUS_W-1:0] n_status;
    t_count              r_count;
    t_count              n_count;
    t_op                 w_op;
    t_op                 n_op;
    logic                w_accept;
    t_row_status         w_row;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    t_word               r_out_front;
    t_word               r_out_back;
    t_count              r_out_count;

    assign o_in_stall = r_pend | (r_out_valid & i_out_stall);
    assign w_accept   = i_in_valid & ~o_in_stall;

    // Decode the command; a rejected push or pop leaves the row alone.
    always_comb begin
        n_op     = OP_HOLD;
        n_status = ST_OK;
        n_count  = r_count;
        case (i_mode)
            MODE_PUSH_FRONT: begin
                if (w_row.full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op    = OP_PUSH_FRONT;
                    n_count = r_count + t_count'(1);
                end
            end
            MODE_PUSH_BACK: begin
                if (w_row.full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op    = OP_PUSH_BACK;
                    n_count = r_count + t_count'(1);
                end
            end
            MODE_POP_FRONT: begin
                if (w_row.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_op    = OP_POP_FRONT;
                    n_count = r_count - t_count'(1);
                end
            end
            MODE_POP_BACK: begin
                if (w_row.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_op    = OP_POP_BACK;
                    n_count = r_count - t_count'(1);
                end
            end
            default: begin
                n_op = OP_HOLD;
            end
        endcase
    end

    assign w_op = w_accept ? n_op : OP_HOLD;

    dq_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_word  (t_word'(i_data)),
        .o_status(w_row)
    );

    // Count and the word in flight between the row and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            r_pend <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= n_status;
        end
    end

    // Result register, loaded once the row has settled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out_status <= r_pend_status;
            r_out_front  <= w_row.front;
            r_out_back   <= w_row.back;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_front_value = PORT_W'(r_out_front);
    assign o_back_value  = PORT_W'(r_out_back);
    assign o_count       = COUNT_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);

    `DQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= t_count'(DEPTH), "count above depth")
    `DQ_ASSERT(a_empty_match, i_clk, i_rst_n, w_row.empty == (r_count == '0), "empty flag mismatch")
    `DQ_ASSERT(a_full_match, i_clk, i_rst_n, w_row.full == (r_count == t_count'(DEPTH)), "full flag mismatch")
    `DQ_ASSERT(a_pend_loads, i_clk, i_rst_n, r_pend |=> r_out_valid, "result not loaded")
    `DQ_ASSERT(a_no_overrun, i_clk, i_rst_n, r_pend |-> !(r_out_valid && i_out_stall), "result overrun")

endmodule
`default_nettype wire

// ===== bench/double_ended_queue_tb.sv =====
`default_nettype none
module double_ended_queue_tb;
    import dq_pkg::*;

    // One result word as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PORT_W-1:0]   front;
        logic [PORT_W-1:0]   back;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } t_dq_result;

    // One command word, with an optional hand-written expected result.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PORT_W-1:0] data;
        logic              typed;
        t_dq_result        want;
    } t_cmd;

    // Receiver stall patterns and the flavors of random command mix.
    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_RUNS} t_stall_pat;
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_ANY} t_mix;

    localparam logic [MODE_W-1:0] MODE_UNUSED_TOP = 3'd7;
    localparam logic [PORT_W-1:0] WORD_MASK =
        (DATA_WIDTH >= PORT_W) ? '1 : PORT_W'((64'd1 << DATA_WIDTH) - 64'd1);
    localparam t_dq_result NO_WANT = '0;
    localparam int DIR_ROWS     = 24;
    localparam int RANDOM_ITEMS = 1226;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [MODE_W-1:0]   i_mode      = '0;
    logic [PORT_W-1:0]   i_data      = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [PORT_W-1:0]   o_front_value;
    logic [PORT_W-1:0]   o_back_value;
    logic [COUNT_W-1:0]  o_count;
    logic                o_is_empty;

    double_ended_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_data        (i_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

    // Directed commands: empty-queue corners, extreme words, a fill to capacity,
    // rejected pushes on a full queue and a pop from each end.
    t_cmd dir_table [DIR_ROWS] = '{
        {MODE_PEEK,       32'h0000_0000, 1'b1, ST_OK,    32'h0, 32'h0, 5'd0, 1'b1},
        {MODE_POP_FRONT,  32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0, 32'h0, 5'd0, 1'b1},
        {MODE_POP_BACK,   32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0, 32'h0, 5'd0, 1'b1},
        {MODE_UNUSED_TOP, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0, 32'h0, 5'd0, 1'b1},
        {MODE_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, ST_OK,    32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                         5'd1, 1'b0},
        {MODE_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_OK,    32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0},
        {MODE_PUSH_BACK,  32'h0000_0001, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'h8000_0000, 1'b0, NO_WANT},
        {MODE_PUSH_BACK,  32'hA5A5_A5A5, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, NO_WANT},
        {MODE_PUSH_BACK,  32'h0000_FFFF, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'hFFFF_0000, 1'b0, NO_WANT},
        {MODE_PUSH_BACK,  32'h1234_5678, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'h8765_4321, 1'b0, NO_WANT},
        {MODE_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, NO_WANT},
        {MODE_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'h8000_0001, 1'b0, NO_WANT},
        {MODE_PUSH_BACK,  32'h0000_0002, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'h4000_0000, 1'b0, NO_WANT},
        {MODE_PUSH_FRONT, 32'hCAFE_0001, 1'b0, NO_WANT},
        {MODE_PUSH_BACK,  32'hCAFE_0002, 1'b0, NO_WANT},
        {MODE_POP_BACK,   32'h0000_0000, 1'b0, NO_WANT},
        {MODE_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT}
    };

    t_cmd       cmd_plan [$];
    t_dq_result due_results [$];

    // Shadow model of the queue, kept as a ring buffer.
    logic [PORT_W-1:0] ring [DEPTH];
    int unsigned       head = 0;
    int unsigned       tail = 0;
    int unsigned       held = 0;

    int         cur        = 0;
    bit         in_took    = 1'b0;
    bit         out_took   = 1'b0;
    bit         draining   = 1'b0;
    int         gap_left   = 0;
    int         burst_left = 1;
    t_stall_pat pat_kind   = STALL_NONE;
    int         pat_left   = 0;
    int         run_left   = 0;
    bit         run_stall  = 1'b0;
    int         idle_cycles    = 0;
    int         faults         = 0;
    int         checked        = 0;
    int         refused_full   = 0;
    int         refused_empty  = 0;
    int         peak_count     = 0;

    // Clock with a period of 4.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_fault(input string what);
        faults++;
        if (faults <= 40) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Applies one command to the shadow ring and returns the result it yields.
    function automatic t_dq_result deque_apply(input logic [MODE_W-1:0] mode,
                                               input logic [PORT_W-1:0] data);
        t_dq_result r;
        logic [PORT_W-1:0] word;
        r = '0;
        r.status = ST_OK;
        word = data & WORD_MASK;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    head = (head == 0) ? DEPTH - 1 : head - 1;
                    ring[head] = word;
                    held++;
                end
            end
            MODE_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring[tail] = word;
                    tail = (tail + 1 == DEPTH) ? 0 : tail + 1;
                    held++;
                end
            end
            MODE_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    head = (head + 1 == DEPTH) ? 0 : head + 1;
                    held--;
                end
            end
            MODE_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    tail = (tail == 0) ? DEPTH - 1 : tail - 1;
                    held--;
                end
            end
            default: begin
            end
        endcase
        // Front and back read as zero on an empty queue.
        if (held != 0) begin
            r.front = ring[head];
            r.back  = ring[(tail == 0) ? DEPTH - 1 : tail - 1];
        end
        r.count = COUNT_W'(held);
        r.empty = (held == 0);
        return r;
    endfunction

    // Inputs change at the falling edge: bursts of command words with gaps,
    // and the result stall on its own pattern.
    always @(negedge i_clk) begin : feed
        logic go;
        logic stall_nxt;
        go = i_in_valid;
        if (in_took) begin
            cur = cur + 1;
            go = 1'b0;
        end
        if (!go && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cur < cmd_plan.size()) begin
                go = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_in_valid <= go;
        if (go) begin
            i_mode <= cmd_plan[cur].mode;
            i_data <= cmd_plan[cur].data;
        end else begin
            i_mode <= MODE_W'($urandom);
            i_data <= $urandom;
        end

        // The result side picks a new stall pattern whenever the current one runs out.
        stall_nxt = 1'b0;
        if (!draining) begin
            if (pat_left == 0) begin
                pat_kind = t_stall_pat'($urandom_range(0, 3));
                pat_left = $urandom_range(40, 150);
            end
            pat_left--;
            case (pat_kind)
                STALL_NONE: begin
                    stall_nxt = 1'b0;
                end
                STALL_COIN: begin
                    stall_nxt = 1'($urandom_range(0, 1));
                end
                STALL_PERIODIC: begin
                    stall_nxt = (pat_left % 3 == 0);
                end
                default: begin
                    if (run_left == 0) begin
                        run_left = $urandom_range(1, 8);
                        run_stall = !run_stall;
                    end
                    run_left--;
                    stall_nxt = run_stall;
                end
            endcase
        end
        i_out_stall <= stall_nxt;
    end

    // At the rising edge: check each result word taken, predict each command
    // word taken, and watch for a stuck handshake.
    always @(posedge i_clk) begin : watch
        t_dq_result want;
        t_dq_result calc;
        in_took = 1'b0;
        out_took = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                out_took = 1'b1;
                if (due_results.size() == 0) begin
                    report_fault("result word with no command waiting");
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status)
                        report_fault($sformatf("result %0d status got %0d want %0d",
                                               checked, o_status, want.status));
                    if (o_front_value !== want.front)
                        report_fault($sformatf("result %0d front got %h want %h",
                                               checked, o_front_value, want.front));
                    if (o_back_value !== want.back)
                        report_fault($sformatf("result %0d back got %h want %h",
                                               checked, o_back_value, want.back));
                    if (o_count !== want.count)
                        report_fault($sformatf("result %0d count got %0d want %0d",
                                               checked, o_count, want.count));
                    if (o_is_empty !== want.empty)
                        report_fault($sformatf("result %0d empty flag got %b want %b",
                                               checked, o_is_empty, want.empty));
                end
                checked++;
            end
            if (i_in_valid && !o_in_stall) begin
                in_took = 1'b1;
                calc = deque_apply(i_mode, i_data);
                due_results.insert(due_results.size(),
                                   cmd_plan[cur].typed ? cmd_plan[cur].want : calc);
                if (calc.status == ST_FULL) refused_full++;
                if (calc.status == ST_EMPTY) refused_empty++;
                if (calc.count > peak_count) peak_count = calc.count;
            end

            // Watchdog on cycles with no handshake at all.
            idle_cycles = (in_took || out_took) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no handshake for %0d cycles, %0d results still due",
                         IDLE_LIMIT, due_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : run
        t_cmd c;
        t_mix mix;
        int   seg_len;
        int   roll;
        bit   push_it;

        // Directed table first.
        for (int i = 0; i < DIR_ROWS; i++) begin
            cmd_plan.insert(cmd_plan.size(), dir_table[i]);
        end

        // Random segments, each biased toward filling, draining or neither.
        while (cmd_plan.size() < DIR_ROWS + RANDOM_ITEMS) begin
            mix = t_mix'($urandom_range(0, 3));
            seg_len = $urandom_range(20, 60);
            repeat (seg_len) begin
                roll = $urandom_range(0, 9);
                push_it = (mix == MIX_FILL)  ? (roll < 7) :
                          (mix == MIX_DRAIN) ? (roll < 3) : (roll < 5);
                c.typed = 1'b0;
                c.want = NO_WANT;
                if (mix == MIX_ANY) begin
                    c.mode = MODE_W'($urandom_range(0, 7));
                end else if (mix == MIX_EVEN && roll == 9) begin
                    c.mode = MODE_PEEK;
                end else if (push_it) begin
                    c.mode = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
                end else begin
                    c.mode = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
                end
                case ($urandom_range(0, 7))
                    0: c.data = '0;
                    1: c.data = '1;
                    2: c.data = PORT_W'(1) << $urandom_range(0, PORT_W - 1);
                    default: c.data = $urandom;
                endcase
                cmd_plan.insert(cmd_plan.size(), c);
            end
        end

        // Reset is held from the start and released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be taken and every result to come back.
        while (cur < cmd_plan.size()) @(negedge i_clk);
        while (due_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (due_results.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", due_results.size()));
        end

        $display("Ran %0d commands (%0d directed); %0d pushes refused on a full queue,",
                 cmd_plan.size(), DIR_ROWS, refused_full);
        $display("%0d pops refused on an empty queue, peak count %0d, %0d results checked.",
                 refused_empty, peak_count, checked);
        if (faults == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", faults);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== double_ended_queue.f =====
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/dq_row.sv
hdl/double_ended_queue.sv
bench/double_ended_queue_tb.sv
